/* rtl/core/ffe_pkg.sv */
// ffe_pkg: shared types and constants of the fix frame extractor
// used by ffe_parser and fix_frame_extractor_top; no dependencies
package ffe_pkg;

    localparam int unsigned MAX_LEN_W            = 21;
    localparam int unsigned COUNT_W              = MAX_LEN_W + 1;
    localparam int unsigned ACCUM_W              = 32;
    localparam int unsigned LEFT_W               = ACCUM_W + 1;
    localparam int unsigned CHECKSUM_FIELD_BYTES = 7;

    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 21'h10000;

    localparam logic [7:0] SOH_BYTE   = 8'h01;
    localparam logic [7:0] CHAR_EIGHT = 8'h38;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_EQ    = 8'h3d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BEGIN    = 3'd1,
        ST_LENTAG   = 3'd2,
        ST_LENVAL   = 3'd3,
        ST_OVERSIZE = 3'd4
    } status_t;

    // per-byte result of the parser
    typedef struct packed {
        logic [7:0] out_byte;
        logic       in_frame;
        logic       frame_end;
        status_t    status;
    } fix_result_t;

    // sticky error state seen by the top level
    typedef struct packed {
        logic    error;
        status_t err_code;
    } fix_status_t;

endpackage

/* rtl/core/fix_frame_extractor_top.sv */
// fix_frame_extractor_top: stream wrapper with output register and config register
// depends on ffe_pkg and ffe_parser
//
// Usage:
//   s_* carries the received byte stream, one byte per transaction in s_tdata.
//   m_* returns one transaction per input byte: the byte echoed in m_tdata,
//   m_tlast high on the last checksum byte of a complete frame, and m_tuser
//   holding the in-frame flag and the status code.
//   cfg_we/cfg_wdata write the maximum frame length; write only while idle.
//   Each input byte's result is registered and valid in the cycle after its
//   transaction. Throughput is one byte per cycle while the receiver is ready:
//   the parser step is short logic (36-bit add for length digits, 22-bit compare).
//   When the receiver stalls, the held result stays in the output register
//   and a new byte is still taken in the same cycle the held one is taken.
//   Reset clears the framing state and any sticky error, empties the output
//   register and sets the maximum frame length to 65536.
//   After a format or oversize error every byte is echoed with in-frame low
//   and the error code, until the next reset.
module fix_frame_extractor_top
    import ffe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] out_byte
    output logic                 m_tlast,   // frame_end
    output logic [7:0]           m_tuser,   // [0] in_frame, [3:1] status, [7:4] zero
    input  logic                 cfg_we,
    input  logic [MAX_LEN_W-1:0] cfg_wdata  // max_frame_len
);

    logic [MAX_LEN_W-1:0] max_len_reg;
    logic                 out_valid_reg;
    fix_result_t          out_reg;
    fix_result_t          result;
    fix_status_t          sts;
    logic                 accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_LEN_RESET;
        else if (cfg_we)
            max_len_reg <= cfg_wdata;
    end

    ffe_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (accept),
        .in_byte       (s_tdata),
        .max_frame_len (max_len_reg),
        .result        (result),
        .sts           (sts)
    );

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_tready)
            out_valid_reg <= s_tvalid;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.out_byte;
    assign m_tlast  = out_reg.frame_end;
    assign m_tuser  = {4'b0, out_reg.status, out_reg.in_frame};

`ifndef ASSERT_OFF
    // end of frame only on a byte taken into a frame
    a_end_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> m_tuser[0])
        else $error("frame end outside a frame");

    // error status never comes with the in-frame flag
    a_err_not_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[3:1] != 3'd0)) |-> !m_tuser[0])
        else $error("error status on an in-frame byte");

    // error state is sticky and its code does not change
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        sts.error |=> (sts.error && $stable(sts.err_code)))
        else $error("sticky error lost or changed");

    // a byte taken while in error reports that error
    a_err_reported: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sts.error) |=> (m_tvalid && (m_tuser[3:1] == $past(sts.err_code))))
        else $error("error code not reported");
`endif

endmodule

/* rtl/core/ffe_parser.sv */
// ffe_parser: framing state machine, one byte per transaction
// depends on ffe_pkg
module ffe_parser
    import ffe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           in_byte,
    input  logic [MAX_LEN_W-1:0] max_frame_len,
    output fix_result_t          result,
    output fix_status_t          sts
);

    typedef enum logic [2:0] {
        PH_TAG8,
        PH_EQ8,
        PH_BEGINVAL,
        PH_TAG9,
        PH_EQ9,
        PH_DIGITS,
        PH_BODY,
        PH_ERROR
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [ACCUM_W-1:0]  accum_reg, accum_next;
    logic                digit_seen_reg, digit_seen_next;
    logic [LEFT_W-1:0]   left_reg, left_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    status_t             err_code_reg, err_code_next;

    status_t             err;
    logic                frame_end;
    logic [COUNT_W-1:0]  count_inc;
    logic                is_digit;
    logic [ACCUM_W+3:0]  accum_ext;
    logic [ACCUM_W+3:0]  accum_x10;

    assign count_inc = count_reg + COUNT_W'(1);
    assign is_digit  = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
    assign accum_ext = {4'b0, accum_reg};
    // times ten by shifts, plus the digit value (low nibble of an ascii digit)
    assign accum_x10 = (accum_ext << 3) + (accum_ext << 1)
                     + {{(ACCUM_W){1'b0}}, in_byte[3:0]};

    // next state and per-byte result
    always_comb
    begin
        phase_next      = phase_reg;
        accum_next      = accum_reg;
        digit_seen_next = digit_seen_reg;
        left_next       = left_reg;
        count_next      = count_reg;
        err_code_next   = err_code_reg;
        err             = ST_OK;
        frame_end       = 1'b0;

        result.out_byte  = in_byte;
        result.in_frame  = 1'b0;
        result.frame_end = 1'b0;
        result.status    = err_code_reg;

        if (phase_reg != PH_ERROR)
        begin
            unique case (phase_reg)
                PH_TAG8:
                begin
                    if (in_byte == CHAR_EIGHT) phase_next = PH_EQ8;
                    else                       err = ST_BEGIN;
                end
                PH_EQ8:
                begin
                    if (in_byte == CHAR_EQ) phase_next = PH_BEGINVAL;
                    else                    err = ST_BEGIN;
                end
                PH_BEGINVAL:
                begin
                    if (in_byte == SOH_BYTE) phase_next = PH_TAG9;
                end
                PH_TAG9:
                begin
                    if (in_byte == CHAR_NINE) phase_next = PH_EQ9;
                    else                      err = ST_LENTAG;
                end
                PH_EQ9:
                begin
                    if (in_byte == CHAR_EQ)
                    begin
                        phase_next      = PH_DIGITS;
                        accum_next      = '0;
                        digit_seen_next = 1'b0;
                    end
                    else
                    begin
                        err = ST_LENTAG;
                    end
                end
                PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        if (accum_x10[ACCUM_W+3:ACCUM_W] != 4'b0)
                        begin
                            err = ST_LENVAL;
                        end
                        else
                        begin
                            accum_next      = accum_x10[ACCUM_W-1:0];
                            digit_seen_next = 1'b1;
                        end
                    end
                    else if ((in_byte == SOH_BYTE) && digit_seen_reg)
                    begin
                        // checksum field keeps the remaining count above zero
                        left_next  = {1'b0, accum_reg}
                                   + LEFT_W'(CHECKSUM_FIELD_BYTES);
                        phase_next = PH_BODY;
                    end
                    else
                    begin
                        err = ST_LENVAL;
                    end
                end
                PH_BODY:
                begin
                    left_next = left_reg - LEFT_W'(1);
                    if (left_reg == LEFT_W'(1))
                    begin
                        frame_end  = 1'b1;
                        phase_next = PH_TAG8;
                    end
                end
                default:
                begin
                    err = ST_BEGIN;
                end
            endcase

            // oversize only when no format error on this byte
            if ((err == ST_OK) && (count_inc > {1'b0, max_frame_len}))
                err = ST_OVERSIZE;

            if (err != ST_OK)
            begin
                err_code_next = err;
                phase_next    = PH_ERROR;
                result.status = err;
            end
            else
            begin
                result.in_frame  = 1'b1;
                result.frame_end = frame_end;
                result.status    = ST_OK;
                if (frame_end)
                begin
                    count_next      = '0;
                    accum_next      = '0;
                    digit_seen_next = 1'b0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
        end
    end

    // state registers, advanced once per accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_TAG8;
            accum_reg      <= '0;
            digit_seen_reg <= 1'b0;
            left_reg       <= '0;
            count_reg      <= '0;
            err_code_reg   <= ST_OK;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            accum_reg      <= accum_next;
            digit_seen_reg <= digit_seen_next;
            left_reg       <= left_next;
            count_reg      <= count_next;
            err_code_reg   <= err_code_next;
        end
    end

    assign sts.error    = (phase_reg == PH_ERROR);
    assign sts.err_code = err_code_reg;

endmodule
